// ===== rtl/core/perttc_pkg.sv =====
// Shared types, constants and helpers for the periodic task timer table.
`timescale 1ns / 1ps

package perttc_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MAXRES = 8;
  localparam int unsigned REP_W  = $clog2(MAXRES + 1);

  localparam logic [6:0]  FRAC_FULL = 7'd100;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_REG    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_IDLE   = 3'd0,
    KIND_FIRED  = 3'd1,
    KIND_REG    = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] period_ticks;
    logic [6:0]  fraction_hundredths;
    logic        single_shot;
    logic [7:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot_index;
    logic       time_wrapped;
    logic       last;
  } out_item_t;

  // Scan token travelling down the chain; open means no slot claimed yet.
  typedef struct packed {
    logic valid;
    logic open;
  } token_t;

  // Settings of a slot being registered.
  typedef struct packed {
    logic [31:0] period;
    logic [6:0]  fraction;
    logic        once;
  } claim_t;

  // Slot index masked to the three bits of the result field.
  function automatic logic [2:0] idx_to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

endpackage

// ===== rtl/core/perttc_in_if.sv =====
// Input channel: valid/ready handshake carrying one command item.
`timescale 1ns / 1ps

interface perttc_in_if
  import perttc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/perttc_out_if.sv =====
// Output channel: valid/ready handshake carrying one result item.
`timescale 1ns / 1ps

interface perttc_out_if
  import perttc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/perttc_cell.sv =====
// One timer slot of the chain: slot state plus the scan token stage.
`timescale 1ns / 1ps

module perttc_cell
  import perttc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        op_tick_i,
  input  token_t      tok_i,
  output token_t      tok_o,
  input  logic [31:0] time_i,
  input  claim_t      claim_i,
  input  logic        rm_i,
  output logic        fired_o,
  output logic        claimed_o
);

  token_t      token_q;
  logic        used_q, used_d;
  logic        once_q;
  logic [31:0] period_q;
  logic [31:0] due_q;
  logic [6:0]  frac_q;
  logic [7:0]  accum_q;

  logic [7:0]  acc_sum;
  logic        acc_over;
  logic        act;

  assign act       = adv_i & token_q.valid;
  assign fired_o   = token_q.valid & op_tick_i & used_q & (due_q <= time_i);
  assign claimed_o = token_q.valid & ~op_tick_i & token_q.open & ~used_q;

  assign tok_o.valid = token_q.valid;
  assign tok_o.open  = token_q.open & ~claimed_o;

  assign acc_sum  = accum_q + {1'b0, frac_q};
  assign acc_over = acc_sum > {1'b0, FRAC_FULL};

  always_comb begin
    used_d = used_q;
    if (rm_i) begin
      used_d = 1'b0;
    end else if (act && fired_o && once_q) begin
      used_d = 1'b0;
    end else if (act && claimed_o) begin
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
      used_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      if (adv_i) begin
        token_q <= tok_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act && fired_o && !once_q) begin
      due_q   <= due_q + period_q + {31'd0, acc_over};
      accum_q <= acc_over ? (acc_sum - {1'b0, FRAC_FULL}) : acc_sum;
    end else if (act && claimed_o) begin
      once_q   <= claim_i.once;
      period_q <= claim_i.period;
      frac_q   <= claim_i.fraction;
      accum_q  <= 8'd0;
      due_q    <= time_i + claim_i.period;
    end
  end

endmodule

// ===== rtl/core/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table: sequencer, chain of slot cells, output stage.
`timescale 1ns / 1ps

// Channel  Port   Dir  Transfer content
// -------  -----  ---  ---------------------------------------------------------
// command  in_i   in   mode, period_ticks, fraction_hundredths, single_shot, slot_select
// result   out_o  out  kind, slot_index, time_wrapped, last
//
// A tick or register command runs a token down the chain of SLOTS cells, one cell per
// cycle while the result side is not stalled, then a flush step. Remove goes straight to
// the flush step after the transfer; an unused mode returns nothing.
// Reset clears the time counter, the slot used bits and all control; slot payload is
// written when a slot is claimed. A stalled result holds the scan in place.
// A fired slot's result is held back until the next one is taken, so the final result can carry last.

module periodic_task_timer_table
  import perttc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  perttc_in_if.sink    in_i,
  perttc_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [31:0]      time_q;
  logic             wrap_q;
  logic             op_tick_q;
  logic [IDX_W-1:0] idx_q;
  logic [REP_W-1:0] rep_q;
  claim_t           claim_q;

  out_item_t        pend_q;
  logic             pend_valid_q;

  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             accept, step, inject, adv;
  logic             push;
  out_item_t        push_data;
  logic             take_new;
  out_item_t        new_item;
  logic [6:0]       frac_sat;

  token_t           tok_in  [SLOTS];
  token_t           tok_out [SLOTS];
  logic [SLOTS-1:0] fired, claimed;
  logic             fire_any, claim_any;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid & in_i.ready;
  assign step        = ~out_valid_q | out_o.ready;
  assign inject      = accept &
                       ((in_i.data.mode == MODE_TICK) || (in_i.data.mode == MODE_REG));
  assign adv         = inject | ((state_q == ST_SCAN) & step);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign frac_sat = (in_i.data.fraction_hundredths > FRAC_FULL) ?
                    FRAC_FULL : in_i.data.fraction_hundredths;

  // Cell chain: the token enters at slot 0 and moves one cell per scan step.
  assign tok_in[0] = '{valid: inject, open: inject};

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign tok_in[g] = tok_out[g-1];
    end
    perttc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .op_tick_i (op_tick_q),
      .tok_i     (tok_in[g]),
      .tok_o     (tok_out[g]),
      .time_i    (time_q),
      .claim_i   (claim_q),
      .rm_i      (accept && (in_i.data.mode == MODE_REMOVE) &&
                  (in_i.data.slot_select == 8'(g))),
      .fired_o   (fired[g]),
      .claimed_o (claimed[g])
    );
  end

  assign fire_any  = |fired;
  assign claim_any = |claimed;

  // Result of the cell holding the token; capped at MAXRES reported firings.
  always_comb begin
    take_new = 1'b0;
    new_item = '0;
    if (op_tick_q) begin
      take_new = fire_any && (rep_q < REP_W'(MAXRES));
      new_item = '{kind: KIND_FIRED, slot_index: idx_to_slot(idx_q),
                   time_wrapped: wrap_q, last: 1'b0};
    end else begin
      take_new = claim_any;
      new_item = '{kind: KIND_REG, slot_index: idx_to_slot(idx_q),
                   time_wrapped: 1'b0, last: 1'b0};
    end
  end

  always_comb begin
    state_d   = state_q;
    push      = 1'b0;
    push_data = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority case (in_i.data.mode)
            MODE_TICK, MODE_REG: state_d = ST_SCAN;
            MODE_REMOVE:         state_d = ST_FLUSH;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (step) begin
          push = take_new & pend_valid_q;
          if (tok_out[SLOTS-1].valid) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (step) begin
          push = 1'b1;
          if (pend_valid_q) begin
            push_data      = pend_q;
            push_data.last = 1'b1;
          end else begin
            push_data = '{kind: op_tick_q ? KIND_IDLE : KIND_FULL, slot_index: 3'd0,
                          time_wrapped: wrap_q, last: 1'b1};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_q       <= 32'd0;
      wrap_q       <= 1'b0;
      op_tick_q    <= 1'b0;
      idx_q        <= '0;
      rep_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (accept) begin
        idx_q <= '0;
        rep_q <= '0;
        unique case (in_i.data.mode)
          MODE_TICK: begin
            time_q       <= time_q + 32'd1;
            wrap_q       <= (time_q == TIME_MAX);
            op_tick_q    <= 1'b1;
            pend_valid_q <= 1'b0;
          end
          MODE_REG: begin
            wrap_q       <= 1'b0;
            op_tick_q    <= 1'b0;
            pend_valid_q <= 1'b0;
          end
          MODE_REMOVE: begin
            wrap_q       <= 1'b0;
            pend_valid_q <= 1'b1;
          end
          MODE_NONE: begin
            pend_valid_q <= 1'b0;
          end
          default: pend_valid_q <= 1'b0;
        endcase
      end else if (state_q == ST_SCAN && step) begin
        idx_q <= idx_q + IDX_W'(1);
        if (take_new) begin
          pend_valid_q <= 1'b1;
          if (op_tick_q) begin
            rep_q <= rep_q + REP_W'(1);
          end
        end
      end else if (state_q == ST_FLUSH && step) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= push_data;
    end
    if (accept && in_i.data.mode == MODE_REG) begin
      claim_q.period   <= in_i.data.period_ticks;
      claim_q.fraction <= frac_sat;
      claim_q.once     <= in_i.data.single_shot;
    end
    if (accept && in_i.data.mode == MODE_REMOVE) begin
      pend_q <= '{kind: KIND_REMOVE, slot_index: 3'd0, time_wrapped: 1'b0, last: 1'b0};
    end else if (state_q == ST_SCAN && step && take_new) begin
      pend_q <= new_item;
    end
  end

endmodule

// ===== tb/periodic_task_timer_table_checker.sv =====
// Checker for the periodic task timer table: mirrors the slot table and compares results.
`timescale 1ns / 1ps

module periodic_task_timer_table_checker
  import perttc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  logic      cmd_ready_i,
  input  in_item_t  cmd_data_i,
  input  logic      res_valid_i,
  input  logic      res_ready_i,
  input  out_item_t res_data_i,
  output int        pending_o,
  output int        errors_o
);

  // Mirror of the slot table
  logic [31:0] now_ticks;
  logic [3:0]  busy_slots;
  logic        slot_live  [SLOTS];
  logic        slot_single[SLOTS];
  logic [31:0] slot_len   [SLOTS];
  logic [31:0] slot_next  [SLOTS];
  logic [6:0]  slot_frac  [SLOTS];
  logic [7:0]  slot_carry [SLOTS];

  out_item_t   results_owed[$];
  int          err_cnt;

  function automatic int field_differs(input string name, input logic [2:0] want,
                                       input logic [2:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    return 1;
  endfunction

  // Advances the table by one command and queues the results it owes.
  task automatic apply_command(input in_item_t cmd);
    logic        wrap;
    logic [8:0]  acc;
    logic [6:0]  frac;
    int          fired;
    int          pick;
    int          i;
    bit          have_held;
    out_item_t   held;
    fired     = 0;
    pick      = -1;
    have_held = 1'b0;
    held      = '0;
    case (cmd.mode)
      MODE_TICK: begin
        wrap      = (now_ticks == TIME_MAX);
        now_ticks = now_ticks + 32'd1;
        for (i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_next[i] <= now_ticks) begin
            if (slot_single[i]) begin
              slot_live[i] = 1'b0;
              if (busy_slots != 4'd0) busy_slots = busy_slots - 4'd1;
            end else begin
              acc          = {1'b0, slot_carry[i]} + {2'b00, slot_frac[i]};
              slot_next[i] = slot_next[i] + slot_len[i];
              if (acc > {2'b00, FRAC_FULL}) begin
                slot_next[i] = slot_next[i] + 32'd1;
                acc          = acc - {2'b00, FRAC_FULL};
              end
              slot_carry[i] = acc[7:0];
            end
            // held back one firing so the final one can carry last
            if (fired < MAXRES) begin
              if (have_held) results_owed.push_back(held);
              held              = '0;
              held.kind         = KIND_FIRED;
              held.slot_index   = i[2:0];
              held.time_wrapped = wrap;
              have_held         = 1'b1;
              fired++;
            end
          end
        end
        if (!have_held) begin
          held              = '0;
          held.kind         = KIND_IDLE;
          held.time_wrapped = wrap;
        end
        held.last = 1'b1;
        results_owed.push_back(held);
      end
      MODE_REG: begin
        if (busy_slots < SLOTS) begin
          for (i = 0; i < SLOTS; i++) begin
            if (pick < 0 && !slot_live[i]) pick = i;
          end
        end
        held.last = 1'b1;
        if (pick < 0) begin
          held.kind = KIND_FULL;
        end else begin
          frac = (cmd.fraction_hundredths > FRAC_FULL) ? FRAC_FULL
                                                       : cmd.fraction_hundredths;
          slot_live[pick]   = 1'b1;
          slot_single[pick] = cmd.single_shot;
          slot_len[pick]    = cmd.period_ticks;
          slot_frac[pick]   = frac;
          slot_carry[pick]  = 8'd0;
          slot_next[pick]   = now_ticks + cmd.period_ticks;
          busy_slots        = busy_slots + 4'd1;
          held.kind         = KIND_REG;
          held.slot_index   = pick[2:0];
        end
        results_owed.push_back(held);
      end
      MODE_REMOVE: begin
        if (cmd.slot_select < SLOTS && slot_live[cmd.slot_select[IDX_W-1:0]]) begin
          slot_live[cmd.slot_select[IDX_W-1:0]] = 1'b0;
          if (busy_slots != 4'd0) busy_slots = busy_slots - 4'd1;
        end
        held.kind = KIND_REMOVE;
        held.last = 1'b1;
        results_owed.push_back(held);
      end
      default: ; // unused mode: no effect, no result
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_ticks  = '0;
      busy_slots = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i]   = 1'b0;
        slot_single[i] = 1'b0;
        slot_len[i]    = '0;
        slot_next[i]   = '0;
        slot_frac[i]   = '0;
        slot_carry[i]  = '0;
      end
      results_owed.delete();
      err_cnt    = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // results first: one leaving now cannot stem from a command taken now
      if (res_valid_i && res_ready_i) begin
        if (results_owed.size() == 0) begin
          $display("%0t: unexpected result, expected none %s %0d slot %0d wrap %0b last %0b",
                   $time, "actual kind", res_data_i.kind, res_data_i.slot_index,
                   res_data_i.time_wrapped, res_data_i.last);
          err_cnt++;
        end else begin
          out_item_t want;
          want    = results_owed.pop_front();
          err_cnt += field_differs("kind", want.kind, res_data_i.kind);
          err_cnt += field_differs("slot_index", want.slot_index, res_data_i.slot_index);
          err_cnt += field_differs("time_wrapped", {2'b00, want.time_wrapped},
                                   {2'b00, res_data_i.time_wrapped});
          err_cnt += field_differs("last", {2'b00, want.last}, {2'b00, res_data_i.last});
        end
      end
      if (cmd_valid_i && cmd_ready_i) apply_command(cmd_data_i);
      pending_o <= results_owed.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ===== tb/periodic_task_timer_table_tb.sv =====
// Testbench top for the periodic task timer table: stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module periodic_task_timer_table_tb;
  import perttc_pkg::*;

  localparam int RANDOM_ITEMS = 126;
  localparam int PHASE_LEN    = 42;
  localparam int HOLD_AT      = 60;     // commands sent before the long result hold-off
  localparam int LONG_HOLD    = 300;    // cycles with ready low
  localparam int DRAIN_CYCLES = 2 * SLOTS + 4;
  localparam int LIMIT        = 200000;

  logic clk_i;
  logic rst_ni;

  perttc_in_if  cmd_if ();
  perttc_out_if res_if ();

  int send_gap_pct;   // chance in a hundred, at each draw, that the sender idles
  int take_gap_pct;   // same for the result side
  int sent_cnt;       // command transfers so far
  int owed;           // results still outstanding, as seen by the checker
  int fails;

  periodic_task_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  periodic_task_timer_table_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_if.valid),
    .cmd_ready_i (cmd_if.ready),
    .cmd_data_i  (cmd_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.data),
    .pending_o   (owed),
    .errors_o    (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one command, idling beforehand at the current rate, and returns once it
  // has been transferred. valid stays high so back-to-back commands need no new edge.
  task automatic offer(input logic [1:0] mode, input logic [31:0] period,
                       input logic [6:0] frac, input logic once, input logic [7:0] sel);
    in_item_t cmd;
    cmd.mode                = mode;
    cmd.period_ticks        = period;
    cmd.fraction_hundredths = frac;
    cmd.single_shot         = once;
    cmd.slot_select         = sel;
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= cmd;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent_cnt <= sent_cnt + 1;
  endtask

  // Sender pause: hold off until every owed result has come back. The first edge is
  // always taken so a command transferred at the last edge is already counted.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  // Result side: random stalls at the phase rate, plus one long hold-off partway into
  // the run so that the table backs up and the command side has to stall.
  initial begin : take_side
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  // Watchdog on a cycle count.
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("periodic_task_timer_table_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int          done_items;
    int          pick;
    logic [1:0]  mode;
    logic [31:0] period;
    logic [6:0]  frac;
    logic        once;
    logic [7:0]  sel;

    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    sent_cnt     = 0;
    send_gap_pct = 18;
    take_gap_pct = 49;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Empty table first: a tick with nothing due, then the unused mode
    // with every field bit set, which must leave no trace.
    offer(MODE_TICK,   32'd0,         7'd0,   1'b0, 8'd0);
    offer(MODE_NONE,   32'hFFFF_FFFF, 7'd127, 1'b1, 8'hFF);
    // Fill all eight slots: zero period, fractions at and above full scale (saturated),
    // a period of all ones whose due time wraps below now, a far-off due time.
    offer(MODE_REG,    32'd0,         7'd127, 1'b0, 8'd0);
    offer(MODE_REG,    32'd1,         7'd100, 1'b1, 8'd0);
    offer(MODE_REG,    32'hFFFF_FFFF, 7'd0,   1'b0, 8'd0);
    offer(MODE_REG,    32'd3,         7'd50,  1'b0, 8'd0);
    offer(MODE_REG,    32'd2,         7'd101, 1'b1, 8'd0);
    offer(MODE_REG,    32'h8000_0000, 7'd1,   1'b0, 8'd0);
    offer(MODE_REG,    32'd5,         7'd99,  1'b0, 8'd0);
    offer(MODE_REG,    32'd1,         7'd0,   1'b1, 8'd0);
    // table full
    offer(MODE_REG,    32'd4,         7'd10,  1'b0, 8'd0);
    // several slots fire per tick; one-shots free themselves
    repeat (5) offer(MODE_TICK, 32'd0, 7'd0, 1'b0, 8'd0);
    // remove out of range, just past the end, a slot already freed, a live slot
    offer(MODE_REMOVE, 32'd0,         7'd0,   1'b0, 8'hFF);
    offer(MODE_REMOVE, 32'd0,         7'd0,   1'b0, SLOTS[7:0]);
    offer(MODE_REMOVE, 32'd0,         7'd0,   1'b0, 8'd1);
    offer(MODE_REMOVE, 32'd0,         7'd0,   1'b0, 8'd5);
    // one-shot with zero period takes the lowest free slot and fires next tick
    offer(MODE_REG,    32'd0,         7'd100, 1'b1, 8'd0);
    offer(MODE_TICK,   32'd0,         7'd0,   1'b0, 8'd0);
    offer(MODE_REMOVE, 32'd0,         7'd0,   1'b0, 8'd0);
    offer(MODE_REMOVE, 32'd0,         7'd0,   1'b0, 8'd2);
    offer(MODE_TICK,   32'd0,         7'd0,   1'b0, 8'd0);
    wait_drained();

    // Random part in three idling phases: sender light and receiver heavy, then the
    // other way round, then no idling at all. Each phase starts from a drained block.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items == PHASE_LEN) begin
        wait_drained();
        send_gap_pct  = 49;
        take_gap_pct <= 18;
      end else if (done_items == 2 * PHASE_LEN) begin
        wait_drained();
        send_gap_pct  = 0;
        take_gap_pct <= 0;
      end

      pick = $urandom_range(99);
      if (pick < 48)      mode = MODE_TICK;
      else if (pick < 75) mode = MODE_REG;
      else if (pick < 95) mode = MODE_REMOVE;
      else                mode = MODE_NONE;

      // short periods keep slots firing; some huge ones and some near the top,
      // whose due time wraps and so fires at once
      case ($urandom_range(9))
        0:       period = $urandom;
        1:       period = 32'hFFFF_FFFF - $urandom_range(4);
        default: period = $urandom_range(12);
      endcase
      frac = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
      once = 1'($urandom_range(1));
      sel  = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(SLOTS - 1));

      offer(mode, period, frac, once, sel);
      if (mode != MODE_NONE) done_items++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && owed == 0) begin
      $display("periodic_task_timer_table_tb: done, clean");
    end else begin
      $display("periodic_task_timer_table_tb: done, errors");
    end
    $finish;
  end

endmodule
